@@ sv/bmte_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block matrix text encrypt: shared package
// Dimension, derived widths, request codes and the command record that
// travels from the front end to the multiply engine.
// ---------------------------------------------------------------------------
package bmte_pkg;

    // Matrix dimension (2 to 8)
    localparam int DIM       = 5;
    localparam int KEY_CELLS = DIM * DIM;

    // Derived widths
    localparam int KIDX_W = $clog2(KEY_CELLS);
    localparam int VIDX_W = $clog2(DIM);
    localparam int CNT_W  = $clog2(DIM + 1);
    localparam int ACC_W  = 20;

    // Value used for empty slots of a partial vector
    localparam logic [7:0] PAD_VALUE = 8'd5;

    // Command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input request codes
    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_BYTE = 2'd1,
        MODE_END  = 2'd2
    } mode_t;

    // Commands for the multiply engine
    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_BYTE  = 2'd1,
        OP_FLUSH = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [KIDX_W-1:0]        kidx;
        logic signed [8:0]        kval;
        logic [7:0]               char_val;
        logic [VIDX_W-1:0]        slot;
        logic [CNT_W-1:0]         len;
    } op_t;

endpackage

@@ sv/bmte_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block matrix text encrypt: front end
// Accepts requests, tracks the vector fill count and turns each request
// into a command for the engine; requests with no effect are dropped.
// ---------------------------------------------------------------------------
module bmte_front
    import bmte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [5:0]        key_index,
    input  logic signed [8:0] key_value,
    input  logic [7:0]        char_code,
    output logic              push,
    output op_t               push_op,
    input  logic              push_ready
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             accept;
    logic             push_ok;

    assign in_stall = !push_ready;
    assign accept   = in_valid && push_ready;
    assign push     = accept && push_ok;

    // Classify the request
    always_comb
    begin
        push_op.kind     = OP_KEY;
        push_op.kidx     = key_index[KIDX_W-1:0];
        push_op.kval     = key_value;
        push_op.char_val = char_code;
        push_op.slot     = fill_reg[VIDX_W-1:0];
        push_op.len      = fill_reg;
        push_ok          = 1'b0;
        fill_next        = fill_reg;
        case (mode)
            MODE_KEY:
            begin
                push_op.kind = OP_KEY;
                // writes beyond the matrix are ignored
                push_ok      = ({1'b0, key_index} < 7'(KEY_CELLS));
            end
            MODE_BYTE:
            begin
                push_op.kind = OP_BYTE;
                push_ok      = 1'b1;
                if (fill_reg == CNT_W'(DIM - 1))
                    fill_next = '0;
                else
                    fill_next = fill_reg + CNT_W'(1);
            end
            MODE_END:
            begin
                push_op.kind = OP_FLUSH;
                // nothing pending: nothing to emit
                push_ok      = (fill_reg != '0);
                fill_next    = '0;
            end
            default:
            begin
                push_ok = 1'b0;
            end
        endcase
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

endmodule

@@ sv/bmte_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block matrix text encrypt: command queue
// Short FIFO between the front end and the multiply engine.
// ---------------------------------------------------------------------------
module bmte_queue
    import bmte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic push_ready,
    output logic pop_valid,
    output op_t  pop_op,
    input  logic pop
);

    op_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ sv/bmte_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block matrix text encrypt: multiply engine
// Holds the key matrix and the byte vector, and runs one multiply-accumulate
// per cycle over each key row while the output is free, with an output register.
// ---------------------------------------------------------------------------
module bmte_back
    import bmte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  op_t               q_op,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [19:0] cipher_value,
    output logic [2:0]        row_number,
    output logic              last_of_block
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT
    } state_t;

    state_t                   state_reg;
    logic signed [8:0]        key_mem [KEY_CELLS];
    logic [7:0]               vec_mem [DIM];
    logic [7:0]               calc_vec [DIM];
    logic [CNT_W-1:0]         len_reg;
    logic [VIDX_W-1:0]        row_reg;
    logic [VIDX_W-1:0]        col_reg;
    logic [KIDX_W-1:0]        kaddr_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [ACC_W-1:0]  cipher_reg;
    logic [2:0]               row_out_reg;
    logic                     last_reg;

    logic                     out_free;
    logic                     emit;
    logic signed [8:0]        key_q;
    logic [7:0]               vec_q;
    logic signed [17:0]       prod;
    logic signed [ACC_W-1:0]  sum;
    logic                     last_col;
    logic                     last_row;
    logic                     start;
    logic                     q_last_slot;

    assign out_valid     = out_valid_reg;
    assign cipher_value  = cipher_reg;
    assign row_number    = row_out_reg;
    assign last_of_block = last_reg;

    assign out_free    = !out_valid_reg || !out_stall;
    assign last_col    = (col_reg == VIDX_W'(DIM - 1));
    assign last_row    = (row_reg == VIDX_W'(DIM - 1));
    assign q_last_slot = (q_op.slot == VIDX_W'(DIM - 1));

    // A row total enters the output register this cycle
    assign emit = out_free &&
                  (((state_reg == ST_CALC) && last_col) || (state_reg == ST_WAIT));

    // Multiply-accumulate datapath; slots past the fill length read as pad
    assign key_q = key_mem[kaddr_reg];
    assign vec_q = (CNT_W'(col_reg) < len_reg) ? calc_vec[col_reg] : PAD_VALUE;
    assign prod  = key_q * $signed({1'b0, vec_q});
    assign sum   = acc_reg + ACC_W'(prod);

    // Command pop: anything when idle, non-completing bytes while busy
    always_comb
    begin
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            ST_CALC,
            ST_WAIT: q_pop = q_valid && (q_op.kind == OP_BYTE) && !q_last_slot;
            default: q_pop = 1'b0;
        endcase
    end

    assign start = q_pop && (state_reg == ST_IDLE) &&
                   ((q_op.kind == OP_FLUSH) || ((q_op.kind == OP_BYTE) && q_last_slot));

    // Key matrix, collecting vector and working vector snapshot
    always_ff @(posedge clk)
    begin
        if (q_pop && (q_op.kind == OP_KEY))
            key_mem[q_op.kidx] <= q_op.kval;
        if (q_pop && (q_op.kind == OP_BYTE))
            vec_mem[q_op.slot] <= q_op.char_val;
        if (start)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                if ((q_op.kind == OP_BYTE) && (q_op.slot == VIDX_W'(i)))
                    calc_vec[i] <= q_op.char_val;
                else
                    calc_vec[i] <= vec_mem[i];
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            kaddr_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            cipher_reg    <= '0;
            row_out_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !emit)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        len_reg   <= (q_op.kind == OP_FLUSH) ? q_op.len : CNT_W'(DIM);
                        row_reg   <= '0;
                        col_reg   <= '0;
                        kaddr_reg <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    kaddr_reg <= kaddr_reg + KIDX_W'(1);
                    if (!last_col)
                    begin
                        col_reg <= col_reg + VIDX_W'(1);
                        acc_reg <= sum;
                    end
                    else
                    begin
                        col_reg <= '0;
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            cipher_reg    <= sum;
                            row_out_reg   <= 3'(row_reg);
                            last_reg      <= last_row;
                            acc_reg       <= '0;
                            if (last_row)
                                state_reg <= ST_IDLE;
                            else
                                row_reg <= row_reg + VIDX_W'(1);
                        end
                        else
                        begin
                            // receiver busy: park the row total
                            acc_reg   <= sum;
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        cipher_reg    <= acc_reg;
                        row_out_reg   <= 3'(row_reg);
                        last_reg      <= last_row;
                        acc_reg       <= '0;
                        if (last_row)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            row_reg   <= row_reg + VIDX_W'(1);
                            state_reg <= ST_CALC;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/block_matrix_text_encrypt_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block matrix text encrypt: top level
// Multiplies byte vectors by a signed key matrix with no modulus.
// ---------------------------------------------------------------------------
// Use: the input channel (in_valid / in_stall) carries one request per
// accept: a key entry write (mode 0), a message byte (mode 1) or an end
// of message (mode 2). Load the whole key before the first byte. Every
// DIM bytes, or an end of message with bytes pending (empty slots padded
// with 5), give DIM results on the output channel (out_valid /
// out_stall), one per key row in order, the last flagged.
// A single multiply-accumulate unit works through the key rows in turn.
// Bytes and requests are taken into a two-entry queue while the engine
// works, so the next vector can be collected before the last one is done;
// in_stall rises when that queue is full.
// When out_stall is high the finished row waits in the output register
// and the engine holds the next row total until it can be handed over.
// Reset clears the fill count, queue and sequencer; the key must be
// written again after reset.
// ---------------------------------------------------------------------------
module block_matrix_text_encrypt_top
    import bmte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [5:0]         key_index,
    input  logic signed [8:0]  key_value,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] cipher_value,
    output logic [2:0]         row_number,
    output logic               last_of_block
);

    logic push;
    op_t  push_op;
    logic push_ready;
    logic q_valid;
    op_t  q_op;
    logic q_pop;

    // Request classification and fill tracking
    bmte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .key_index  (key_index),
        .key_value  (key_value),
        .char_code  (char_code),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready)
    );

    // Command queue
    bmte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_op     (q_op),
        .pop        (q_pop)
    );

    // Multiply engine
    bmte_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_value  (cipher_value),
        .row_number    (row_number),
        .last_of_block (last_of_block)
    );

`ifndef SYNTHESIS
    localparam int CIPHER_BOUND = DIM * 256 * 255;

    // Last flag marks exactly the final key row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_block == (row_number == 3'(DIM - 1))))
        else $error("last_of_block does not match row_number");

    // Row number stays within the matrix
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_number <= 3'(DIM - 1)))
        else $error("row_number beyond matrix dimension");

    // Dot product cannot exceed the bound of DIM byte-by-key products
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((cipher_value <= CIPHER_BOUND) && (cipher_value >= -CIPHER_BOUND)))
        else $error("cipher_value outside the reachable range");
`endif

endmodule

@@ bench/block_matrix_text_encrypt_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block matrix text encrypt: testbench
// Loads a key, streams message bytes, key rewrites and end-of-message
// requests, and checks every row total against an in-bench matrix predictor.
// Both channels idle at random. One long output hold-off fills the block.
// ---------------------------------------------------------------------------
module block_matrix_text_encrypt_top_tb;
    import bmte_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 65;
    localparam int         DRAIN_CYCLES = 2 * (DIM * DIM + DIM + 3);
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         HOLD_CYCLES  = 400;

    typedef struct {
        logic [1:0]        mode;
        logic [5:0]        key_index;
        logic signed [8:0] key_value;
        logic [7:0]        char_code;
    } request_t;

    typedef struct {
        logic signed [19:0] cipher;
        logic [2:0]         row;
        logic               last;
    } row_total_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         mode = MODE_KEY;
    logic [5:0]         key_index = '0;
    logic signed [8:0]  key_value = '0;
    logic [7:0]         char_code = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [19:0] cipher_value;
    logic [2:0]         row_number;
    logic               last_of_block;

    // Predictor state
    logic signed [8:0]  key_matrix [KEY_CELLS];
    logic [7:0]         byte_slots [DIM];
    int                 bytes_held = 0;

    request_t           request_queue [$];
    row_total_t         expected_rows [$];
    request_t           current_req;
    int                 accepted_count = 0;
    int                 gap_left = 0;
    int                 stall_left = 0;
    int                 hold_left = 0;
    bit                 hold_done = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;

    block_matrix_text_encrypt_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .key_index     (key_index),
        .key_value     (key_value),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_value  (cipher_value),
        .row_number    (row_number),
        .last_of_block (last_of_block)
    );

    always #2 clk = ~clk;

    // Multiply the held vector by the key, one expected total per row
    task automatic emit_rows();
        int acc;
        row_total_t rt;
        for (int r = 0; r < DIM; r++)
        begin
            acc = 0;
            for (int c = 0; c < DIM; c++)
                acc += int'(key_matrix[r * DIM + c]) * int'(byte_slots[c]);
            rt.cipher = acc[19:0];
            rt.row    = r[2:0];
            rt.last   = (r == DIM - 1);
            expected_rows.push_back(rt);
        end
        bytes_held = 0;
    endtask

    task automatic encrypt_request(request_t req);
        if (req.mode == MODE_KEY)
        begin
            if (req.key_index < KEY_CELLS)
                key_matrix[req.key_index] = req.key_value;
        end
        else if (req.mode == MODE_BYTE)
        begin
            byte_slots[bytes_held] = req.char_code;
            bytes_held++;
            if (bytes_held == DIM)
                emit_rows();
        end
        else if (req.mode == MODE_END && bytes_held != 0)
        begin
            for (int i = bytes_held; i < DIM; i++)
                byte_slots[i] = PAD_VALUE;
            emit_rows();
        end
    endtask

    // Stimulus helpers: fields a mode does not use are random
    function automatic request_t random_request(logic [1:0] m);
        request_t req;
        req.mode      = m;
        req.key_index = 6'($urandom_range(0, 63));
        req.key_value = 9'($urandom_range(0, 510) - 255);
        req.char_code = 8'($urandom_range(0, 255));
        return req;
    endfunction

    task automatic push_key(int idx, int val);
        request_t req;
        req = random_request(MODE_KEY);
        req.key_index = 6'(idx);
        req.key_value = 9'(val);
        request_queue.push_back(req);
    endtask

    task automatic push_byte(int ch);
        request_t req;
        req = random_request(MODE_BYTE);
        req.char_code = 8'(ch);
        request_queue.push_back(req);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                encrypt_request(current_req);
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    current_req = request_queue.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= current_req.mode;
                    key_index <= current_req.key_index;
                    key_value <= current_req.key_value;
                    char_code <= current_req.char_code;
                    // back-to-back stretch
                    gap_left  <= (accepted_count >= 40 && accepted_count < 70) ? 0 : pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: one long hold-off, a quiet window, otherwise random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (!hold_done && accepted_count >= 40)
        begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (accepted_count >= 75 && accepted_count < 100)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 70)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rows.size() == 0)
            begin
                $display("%0t: unexpected result: cipher_value %0d row_number %0d",
                         $time, cipher_value, row_number);
                fail_count++;
            end
            else
            begin
                row_total_t exp_row;
                exp_row = expected_rows.pop_front();
                if (cipher_value !== exp_row.cipher)
                begin
                    $display("%0t: cipher_value expected %0d, got %0d",
                             $time, exp_row.cipher, cipher_value);
                    fail_count++;
                end
                if (row_number !== exp_row.row)
                begin
                    $display("%0t: row_number expected %0d, got %0d",
                             $time, exp_row.row, row_number);
                    fail_count++;
                end
                if (last_of_block !== exp_row.last)
                begin
                    $display("%0t: last_of_block expected %0d, got %0d",
                             $time, exp_row.last, last_of_block);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int pushed;
        int r;

        // Full key: top row at the positive extreme, next row at -255
        for (int i = 0; i < KEY_CELLS; i++)
        begin
            if (i < DIM)
                push_key(i, 255);
            else if (i < 2 * DIM)
                push_key(i, -255);
            else if (i == 2 * DIM)
                push_key(i, 0);
            else
                push_key(i, $urandom_range(0, 510) - 255);
        end
        // end of message with nothing held
        request_queue.push_back(random_request(MODE_END));
        // largest and smallest bytes
        for (int i = 0; i < DIM; i++)
            push_byte(255);
        for (int i = 0; i < DIM; i++)
            push_byte(0);
        // key writes beyond the matrix are dropped
        push_key(63, 255);
        push_key(KEY_CELLS, -255);
        request_queue.push_back(random_request(MODE_UNUSED));
        // key rewrite while bytes are held, then a padded vector
        push_byte(1);
        push_byte(128);
        push_key($urandom_range(0, KEY_CELLS - 1), -1);
        request_queue.push_back(random_request(MODE_END));

        // Random traffic, mostly bytes
        pushed = 0;
        while (pushed < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                push_byte($urandom_range(0, 255));
            else if (r < 79)
                request_queue.push_back(random_request(MODE_END));
            else if (r < 91)
                push_key($urandom_range(0, KEY_CELLS - 1), $urandom_range(0, 510) - 255);
            else if (r < 96)
                push_key($urandom_range(KEY_CELLS, 63), $urandom_range(0, 510) - 255);
            else
                request_queue.push_back(random_request(MODE_UNUSED));
            pushed++;
        end
        request_queue.push_back(random_request(MODE_END));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_valid || expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bmte_pkg.sv
sv/bmte_front.sv
sv/bmte_queue.sv
sv/bmte_back.sv
sv/block_matrix_text_encrypt_top.sv
bench/block_matrix_text_encrypt_top_tb.sv
